// File: rtl/wpm_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and helpers for the wildcard pattern matcher
// no dependencies; imported by every rtl file of the block
package wpm_pkg;

  // pattern store capacity, one cell per pattern byte
  localparam int PatternMax = 32;

  // wildcard bytes
  localparam logic [7:0] SYM_STAR = 8'h2A;
  localparam logic [7:0] SYM_ANY  = 8'h3F;

  // item operation codes
  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_TEXT   = 2'd2,
    OP_END    = 2'd3
  } op_t;

  // input item
  typedef struct packed {
    op_t        operation;
    logic [7:0] symbol;
  } in_t;

  // result item
  typedef struct packed {
    logic matched;
    logic pattern_overflow;
  } out_t;

  // per-transfer control broadcast to every cell
  typedef struct packed {
    logic       clear;
    logic       append;
    logic       restart;
    logic       advance;
    logic [7:0] symbol;
  } cell_ctrl_t;

  // signals handed from one cell to its right neighbor
  typedef struct packed {
    logic valid;  // left cell holds a pattern byte
    logic carry;  // left position is reachable and is a star
    logic step;   // left position consumed the current text byte
  } cell_link_t;

  // ascii upper-casing, other bytes pass unchanged
  function automatic logic [7:0] to_upper(input logic [7:0] c);
    if (c >= 8'h61 && c <= 8'h7A) begin
      return c - 8'h20;
    end
    return c;
  endfunction

endpackage

// File: rtl/wildcard_pattern_matcher_core.sv
`timescale 1ns / 1ps
// top level of the wildcard pattern matcher: row of pattern cells and result buffer
// depends on wpm_pkg, wpm_cell, wpm_out_buf
//
// Usage:
//   in channel (in_valid/in_ready/in_data) carries one operation per transfer:
//   clear pattern, append pattern byte, text byte, or end of text.
//   out channel (out_valid/out_ready/out_data) carries one result per end of
//   text: matched and pattern_overflow.
//   Each pattern position is a cell; a text byte updates every cell at once,
//   with star closure rippling left to right through the row.
//   Throughput: one input transfer per cycle, for every operation, while the skid register is not full.
//   Result: an end-of-text result is registered in the output register, or in
//   the skid register while the receiver stalls.
//   Appending more than PatternMax bytes drops the byte and sets the overflow
//   flag until the next clear. Appending restarts the current text.
//   Reset: empty pattern, overflow flag clear, only position zero reachable,
//   no result pending.
//   Receiver stall: a result waits in the output register and a second one in
//   a skid register; in_ready drops only while the skid register is full.
module wildcard_pattern_matcher_core
  import wpm_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  logic       in_fire;
  cell_ctrl_t ctrl;
  cell_link_t cell_link [PatternMax+1];
  logic [PatternMax-1:0] hit;
  logic [PatternMax-1:0] vld_vec;
  logic       act_last;
  logic       hit_last;
  logic       overflow_flag;
  logic       push;
  out_t       res;
  logic       can_push;
  logic       skid_valid;

  assign in_ready = can_push;
  assign in_fire  = in_valid & in_ready;

  // decode the transfer into cell controls
  always_comb begin
    ctrl.clear   = 1'b0;
    ctrl.append  = 1'b0;
    ctrl.restart = 1'b0;
    ctrl.advance = 1'b0;
    ctrl.symbol  = in_data.symbol;
    if (in_fire) begin
      case (in_data.operation)
        OP_CLEAR: begin
          ctrl.clear   = 1'b1;
          ctrl.restart = 1'b1;
        end
        OP_APPEND: begin
          ctrl.append  = 1'b1;
          ctrl.restart = 1'b1;
        end
        OP_TEXT: begin
          ctrl.advance = 1'b1;
        end
        OP_END: begin
          ctrl.restart = 1'b1;
        end
        default: begin
          ctrl.restart = 1'b0;
        end
      endcase
    end
  end

  // left boundary of the row
  assign cell_link[0].valid = 1'b1;
  assign cell_link[0].carry = 1'b0;
  assign cell_link[0].step  = 1'b0;

  // row of pattern cells
  for (genvar i = 0; i < PatternMax; i++) begin : g_cell
    wpm_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .origin   (i == 0),
      .ctrl     (ctrl),
      .link_in  (cell_link[i]),
      .link_out (cell_link[i+1]),
      .hit      (hit[i])
    );
    assign vld_vec[i] = cell_link[i+1].valid;
  end

  // position past the last cell: reachable only, no byte
  always_ff @(posedge clk) begin
    if (rst || ctrl.restart) begin
      act_last <= 1'b0;
    end else if (ctrl.advance) begin
      act_last <= cell_link[PatternMax].step;
    end
  end

  assign hit_last = (act_last | cell_link[PatternMax].carry) & cell_link[PatternMax].valid;

  // overflow flag
  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      overflow_flag <= 1'b0;
    end else if (ctrl.append && cell_link[PatternMax].valid) begin
      overflow_flag <= 1'b1;
    end
  end

  // result at end of text
  assign push                 = in_fire && (in_data.operation == OP_END);
  assign res.matched          = (|hit) | hit_last;
  assign res.pattern_overflow = overflow_flag;

  wpm_out_buf u_out_buf (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (res),
    .can_push   (can_push),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .skid_valid (skid_valid)
  );

`ifndef NO_ASSERTIONS
  // occupied cells always form a prefix of the row
  a_valid_prefix: assert property (@(posedge clk) disable iff (rst)
    (vld_vec[PatternMax-1:1] & ~vld_vec[PatternMax-2:0]) == '0)
    else $error("pattern cells not contiguous");

  // overflow only rises on an append to a full store
  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    $rose(overflow_flag) |-> $past(cell_link[PatternMax].valid) && $past(ctrl.append))
    else $error("overflow set without full store");

  // an append to a non-full store adds exactly one byte
  a_append_grows: assert property (@(posedge clk) disable iff (rst)
    ctrl.append && !cell_link[PatternMax].valid
    |=> $countones(vld_vec) == $past($countones(vld_vec)) + 1)
    else $error("append did not grow pattern by one");

  // skid entry is only occupied behind a stalled output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds result without output valid");
`endif

endmodule

// File: rtl/wpm_cell.sv
`timescale 1ns / 1ps
// one pattern position: stored byte, occupancy flag and reachability flag
// depends on wpm_pkg
module wpm_cell
  import wpm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       origin,    // high for position zero only
  input  cell_ctrl_t ctrl,
  input  cell_link_t link_in,
  output cell_link_t link_out,
  output logic       hit        // this position is the pattern end and is reachable
);

  logic [7:0] pat;
  logic       valid;
  logic       act;

  logic closed;
  logic end_here;
  logic is_star;
  logic sym_ok;

  // reachability closed over a star on the left
  assign closed   = act | link_in.carry;
  assign end_here = link_in.valid & ~valid;
  assign hit      = closed & end_here;

  // byte compare against the text byte
  assign is_star = (pat == SYM_STAR);
  assign sym_ok  = (pat == SYM_ANY) || (to_upper(pat) == to_upper(ctrl.symbol));

  // hand-off to the right neighbor
  assign link_out.valid = valid;
  assign link_out.carry = closed & valid & is_star;
  assign link_out.step  = closed & valid & ~is_star & sym_ok;

  // pattern byte, written when this is the first free position
  always_ff @(posedge clk) begin
    if (ctrl.append && end_here) begin
      pat <= ctrl.symbol;
    end
  end

  // occupancy
  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      valid <= 1'b0;
    end else if (ctrl.append && end_here) begin
      valid <= 1'b1;
    end
  end

  // reachability before star closure
  always_ff @(posedge clk) begin
    if (rst || ctrl.restart) begin
      act <= origin;
    end else if (ctrl.advance) begin
      act <= (closed & valid & is_star) | link_in.step;
    end
  end

endmodule

// File: rtl/wpm_out_buf.sv
`timescale 1ns / 1ps
// two-entry result buffer: output register plus skid register
// depends on wpm_pkg
module wpm_out_buf
  import wpm_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  out_t push_data,
  output logic can_push,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data,
  output logic skid_valid
);

  out_t skid_data;
  logic drain;

  assign can_push = ~skid_valid;
  assign drain    = ~out_valid | out_ready;

  // output register, refilled from skid first
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (drain) begin
      out_valid <= skid_valid | push;
    end
  end

  always_ff @(posedge clk) begin
    if (drain) begin
      out_data <= skid_valid ? skid_data : push_data;
    end
  end

  // skid register catches a result while the receiver stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      skid_valid <= 1'b0;
    end else if (drain) begin
      skid_valid <= 1'b0;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!drain && push) begin
      skid_data <= push_data;
    end
  end

endmodule
